>>> hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  bytes_valid;
		logic        last_word;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} out_word_t;

	// queue entry: one schedule word plus a final-block marker
	typedef struct packed {
		logic [31:0] data;
		logic        final_blk;
	} sched_word_t;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] r;
		begin
			case (i)
				3'd0: r = 32'h6a09e667;
				3'd1: r = 32'hbb67ae85;
				3'd2: r = 32'h3c6ef372;
				3'd3: r = 32'ha54ff53a;
				3'd4: r = 32'h510e527f;
				3'd5: r = 32'h9b05688c;
				3'd6: r = 32'h1f83d9ab;
				default: r = 32'h5be0cd19;
			endcase
			return r;
		end
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] r;
		begin
			case (i)
				6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491;
				6'd2: r = 32'hb5c0fbcf; 6'd3: r = 32'he9b5dba5;
				6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
				6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5;
				6'd8: r = 32'hd807aa98; 6'd9: r = 32'h12835b01;
				6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
				6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
				6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
				6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
				6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
				6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
				6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
				6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
				6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
				6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
				6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
				6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
				6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
				6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
				6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
				6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
				6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
				6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
				6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
				6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
				6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
				6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
				6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
				6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
				6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
				6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
				6'd62: r = 32'hbef9a3f7;
				default: r = 32'hc67178f2;
			endcase
			return r;
		end
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
		return (v >> s) | (v << (32 - s));
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sha256_front.sv
// ----------------------------------------------------------------------------
// sha256_front
// Accepts message words, pads the final one and emits schedule words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sha256_pkg::in_word_t   in_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output sha256_pkg::sched_word_t     q_data,
	output logic                        q_valid,
	input  wire logic                   q_ready
);

	localparam logic [1:0] ST_MSG = 2'd0;
	localparam logic [1:0] ST_PAD = 2'd1;
	localparam logic [1:0] ST_LHI = 2'd2;
	localparam logic [1:0] ST_LLO = 2'd3;

	logic [1:0]  state_q;
	logic [63:0] bit_count_q;
	logic [3:0]  slot_q;
	logic        need80_q;
	logic [2:0]  nb;
	logic [31:0] mask;
	logic [31:0] padded;
	logic        emit;

	always_comb begin
		nb = (in_data.bytes_valid > 3'd4) ? 3'd4 : in_data.bytes_valid;
		case (nb)
			3'd0: begin mask = 32'h0; padded = 32'h80000000; end
			3'd1: begin mask = 32'hff000000; padded = 32'h00800000; end
			3'd2: begin mask = 32'hffff0000; padded = 32'h00008000; end
			3'd3: begin mask = 32'hffffff00; padded = 32'h00000080; end
			default: begin mask = 32'hffffffff; padded = 32'h0; end
		endcase
		padded = padded | (in_data.message_word & mask);
	end

	assign in_ready = (state_q == ST_MSG) && q_ready;
	assign emit = q_valid && q_ready;

	always_comb begin
		q_valid = 1'b0;
		q_data = '0;
		case (state_q)
			ST_MSG: begin
				q_valid = in_valid;
				q_data.data = (in_data.last_word && nb != 3'd4) ? padded
					: in_data.message_word;
			end
			ST_PAD: begin
				q_valid = 1'b1;
				q_data.data = need80_q ? 32'h80000000 : 32'h0;
			end
			ST_LHI: begin
				q_valid = 1'b1;
				q_data.data = bit_count_q[63:32];
			end
			default: begin
				q_valid = 1'b1;
				q_data.data = bit_count_q[31:0];
				q_data.final_blk = 1'b1;
			end
		endcase
	end

	// slot 15 holds the low length word, so the increment wraps it back to 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MSG;
			bit_count_q <= '0;
			slot_q <= '0;
			need80_q <= 1'b0;
		end else if (emit) begin
			slot_q <= slot_q + 4'd1;
			case (state_q)
				ST_MSG: begin
					if (in_data.last_word) begin
						bit_count_q <= bit_count_q + {58'd0, nb, 3'd0};
						need80_q <= (nb == 3'd4);
						state_q <= (nb != 3'd4 && slot_q == 4'd13) ? ST_LHI : ST_PAD;
					end else begin
						bit_count_q <= bit_count_q + 64'd32;
					end
				end
				ST_PAD: begin
					need80_q <= 1'b0;
					if (slot_q == 4'd13) state_q <= ST_LHI;
				end
				ST_LHI: state_q <= ST_LLO;
				default: begin
					state_q <= ST_MSG;
					bit_count_q <= '0;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == ST_LHI) |-> (slot_q == 4'd14))
		else $error("length high word not at slot 14");
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == ST_LLO) |=> (state_q == ST_MSG && slot_q == 4'd0))
		else $error("front did not return after length");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MSG) |-> !in_ready)
		else $error("input taken while padding");

endmodule

`default_nettype wire

>>> hw/rtl/sha256_queue.sv
// ----------------------------------------------------------------------------
// sha256_queue
// Short FIFO between the word front end and the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sha256_pkg::sched_word_t wr_data,
	input  wire logic                   wr_valid,
	output logic                        wr_ready,
	output sha256_pkg::sched_word_t     rd_data,
	output logic                        rd_valid,
	input  wire logic                   rd_ready
);

	sha256_pkg::sched_word_t mem_q [sha256_pkg::QUEUE_DEPTH];
	logic [sha256_pkg::QUEUE_AW-1:0] wp_q, rp_q;
	logic [sha256_pkg::QUEUE_AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (sha256_pkg::QUEUE_AW+1)'(sha256_pkg::QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + sha256_pkg::QUEUE_AW'(1);
			if (rd) rp_q <= rp_q + sha256_pkg::QUEUE_AW'(1);
			cnt_q <= cnt_q + {{sha256_pkg::QUEUE_AW{1'b0}}, wr} - {{sha256_pkg::QUEUE_AW{1'b0}}, rd};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (sha256_pkg::QUEUE_AW+1)'(sha256_pkg::QUEUE_DEPTH))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (cnt_q == $past(cnt_q) + (sha256_pkg::QUEUE_AW+1)'(1)))
		else $error("queue count slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> (cnt_q == $past(cnt_q) - (sha256_pkg::QUEUE_AW+1)'(1)))
		else $error("queue count slip");

endmodule

`default_nettype wire

>>> hw/rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// Collects 16 schedule words, runs 64 rounds, holds the chaining value and
// emits the digest after the final block.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sha256_pkg::sched_word_t q_data,
	input  wire logic                   q_valid,
	output logic                        q_ready,
	output sha256_pkg::out_word_t       out_data,
	output logic                        out_valid,
	input  wire logic                   out_ready
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_RND  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [3:0]  slot_q;
	logic [5:0]  rnd_q;
	logic        final_q;
	logic [2:0]  oidx_q;
	logic [31:0] w_cur, w15, w2, g0, g1, s1, ch, s0, mj, t1, t2;
	logic        take;

	assign q_ready = (state_q == ST_LOAD);
	assign take = q_valid && q_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word = h_q[oidx_q];
	assign out_data.digest_last = (oidx_q == 3'd7);

	always_comb begin
		w15 = w_q[rnd_q[3:0] + 4'd1];
		w2  = w_q[rnd_q[3:0] + 4'd14];
		g0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
		g1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
		w_cur = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]]
			: w_q[rnd_q[3:0]] + g0 + w_q[rnd_q[3:0] + 4'd9] + g1;
		s1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
			^ sha256_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + sha256_pkg::round_k(rnd_q) + w_cur;
		s0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
			^ sha256_pkg::rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + mj;
	end

	always_ff @(posedge clk) begin
		if (take) w_q[slot_q] <= q_data.data;
		if (state_q == ST_RND) begin
			w_q[rnd_q[3:0]] <= w_cur;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (take && slot_q == 4'd15) begin
			for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			slot_q <= '0;
			rnd_q <= '0;
			final_q <= 1'b0;
			oidx_q <= '0;
			for (int j = 0; j < 8; j++) h_q[j] <= sha256_pkg::init_hash(3'(j));
		end else begin
			case (state_q)
				ST_LOAD: if (take) begin
					slot_q <= slot_q + 4'd1;
					if (slot_q == 4'd15) begin
						final_q <= q_data.final_blk;
						rnd_q <= '0;
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
					oidx_q <= '0;
					state_q <= final_q ? ST_OUT : ST_LOAD;
				end
				default: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						for (int j = 0; j < 8; j++)
							h_q[j] <= sha256_pkg::init_hash(3'(j));
						state_q <= ST_LOAD;
					end
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND && rnd_q == 6'd63) |=> (state_q == ST_ADD))
		else $error("round count slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && slot_q == 4'd15) |=> (state_q == ST_RND && rnd_q == 6'd0))
		else $error("block did not start rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && oidx_q == 3'd7) |=> (state_q == ST_LOAD))
		else $error("digest did not end");

endmodule

`default_nettype wire

>>> hw/rtl/sha256_hash_engine_top.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_top
// SHA-256 engine: message words in, eight digest words out.
//
// Input channel carries big-endian message words; the word marked last says
// how many leading bytes are valid (0..4). Output channel carries the eight
// digest words, word 0 first, digest_last on the eighth.
// The front end pads and appends the 64-bit length and feeds a four-entry
// queue; the core gathers 16 words, then runs the rounds, one round per
// cycle, and the chaining add, taking no new words meanwhile, so the round
// loop sets the sustained rate. After the last word, padding fills the rest
// of its block and, if the length does not fit, a further block; digest
// words follow the final block, one word per cycle while out_ready is high.
// A stalled receiver holds the core in digest output; the queue then fills
// and input ready drops. Reset loads the initial hash and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_hash_engine_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sha256_pkg::in_word_t in_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output sha256_pkg::out_word_t     out_data,
	output logic                      out_valid,
	input  wire logic                 out_ready
);

	sha256_pkg::sched_word_t f_data, c_data;
	logic f_valid, f_ready, c_valid, c_ready;

	sha256_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.q_data(f_data), .q_valid(f_valid), .q_ready(f_ready)
	);

	sha256_queue u_queue (
		.clk, .arst_n,
		.wr_data(f_data), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(c_data), .rd_valid(c_valid), .rd_ready(c_ready)
	);

	sha256_core u_core (
		.clk, .arst_n,
		.q_data(c_data), .q_valid(c_valid), .q_ready(c_ready),
		.out_data, .out_valid, .out_ready
	);

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// SHA-256 engine test: a queue of message words is driven with random bursts
// and gaps; digests predicted in the testbench are checked word by word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	sha256_pkg::in_word_t in_data;
	logic in_valid;
	logic in_ready;
	sha256_pkg::out_word_t out_data;
	logic out_valid;
	logic out_ready;

	sha256_hash_engine_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
	);

	sha256_pkg::in_word_t pending_words[$];
	sha256_pkg::out_word_t digest_q[$];
	int errors = 0;
	bit hold_sender;
	bit long_stall;

	// predictor state
	logic [31:0] hv[8];
	logic [31:0] wblk[16];
	logic [63:0] nbits;
	int slot;

	function automatic logic [31:0] kc(input int i);
		logic [31:0] t[64];
		t = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return t[i];
	endfunction

	function automatic logic [31:0] rr(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic reset_chain();
		hv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		nbits = '0;
		slot = 0;
	endtask

	task automatic compress();
		logic [31:0] v[8];
		logic [31:0] w[64];
		logic [31:0] t1, t2, g0, g1;
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				w[i] = wblk[i];
			end else begin
				g0 = rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3);
				g1 = rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + g0 + w[i-7] + g1;
			end
		end
		v = hv;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc(i) + w[i];
			t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++) hv[j] = hv[j] + v[j];
	endtask

	task automatic schedule_push(input logic [31:0] w);
		wblk[slot] = w;
		slot = (slot + 1) % 16;
		if (slot == 0) compress();
	endtask

	task automatic hash_word(input sha256_pkg::in_word_t it);
		int nb;
		logic [31:0] mask;
		sha256_pkg::out_word_t o;
		if (!it.last_word) begin
			nbits += 32;
			schedule_push(it.message_word);
		end else begin
			nb = (it.bytes_valid > 4) ? 4 : it.bytes_valid;
			nbits += 64'(8 * nb);
			if (nb == 4) begin
				schedule_push(it.message_word);
				schedule_push(32'h80000000);
			end else begin
				mask = (nb == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nb));
				schedule_push((it.message_word & mask) | (32'h80 << (24 - 8 * nb)));
			end
			while (slot != 14) schedule_push(32'h0);
			schedule_push(nbits[63:32]);
			schedule_push(nbits[31:0]);
			for (int k = 0; k < 8; k++) begin
				o.digest_word = hv[k];
				o.digest_last = (k == 7);
				digest_q.push_back(o);
			end
			reset_chain();
		end
	endtask

	task automatic add_word(input logic [31:0] w, input int nb, input bit lst);
		sha256_pkg::in_word_t it;
		it.message_word = w;
		it.bytes_valid = 3'(nb);
		it.last_word = lst;
		pending_words.push_back(it);
	endtask

	// message of n+1 words: n non-last words with random bytes_valid, then a last word with nb bytes
	task automatic add_message(input int n, input int nb);
		for (int i = 0; i < n; i++) add_word($urandom, $urandom_range(0, 7), 0);
		add_word($urandom, nb, 1);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// driver
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
			reset_chain();
		end else if (!in_valid || in_ready) begin
			if (in_valid) hash_word(in_data);
			if (gap_left > 0 || hold_sender || pending_words.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				in_data <= pending_words.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// monitor
	int stall_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected digest word %h", out_data);
				end else if (out_data !== digest_q[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h/%b got %h/%b",
							digest_q[0].digest_word, digest_q[0].digest_last,
							out_data.digest_word, out_data.digest_last);
					void'(digest_q.pop_front());
				end else begin
					void'(digest_q.pop_front());
				end
			end
			if (long_stall && stall_cnt < 600) begin
				out_ready <= 1'b0;
				stall_cnt <= stall_cnt + 1;
			end else begin
				case ($urandom_range(0, 3))
					0: out_ready <= 1'b0;
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || digest_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int remaining;
		hold_sender = 1'b0;
		long_stall = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty message, short tails, oversized count, exact block fill
		add_message(0, 0);
		add_message(0, 1);
		add_message(0, 7);
		add_word(32'hffffffff, 4, 0);
		add_word(32'hffffffff, 3, 1);
		add_word(32'h00000000, 0, 0);
		add_word(32'hffffffff, 2, 1);
		add_message(13, 4);
		add_message(14, 0);
		add_message(15, 5);
		wait_drained();

		// pause and long receiver hold-off while input is offered
		hold_sender = 1'b1;
		repeat (100) @(posedge clk);
		hold_sender = 1'b0;
		add_message(20, 4);
		add_message(3, 2);
		long_stall = 1'b1;
		wait_drained();
		long_stall = 1'b0;

		remaining = 45;
		while (remaining > 0) begin
			int n;
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 17);
			if (n > remaining - 1) n = remaining - 1;
			add_message(n, $urandom_range(0, 7));
			remaining -= n + 1;
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && digest_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

`default_nettype wire
